@@ rtl/core/lifo_srch_pkg.sv @@
package lifo_srch_pkg;

   localparam int DEF_STACK_DEPTH = 64;

   localparam int WORD_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 7;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 48;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_PUSH        = 3'd0;
   localparam mode_type MODE_POP         = 3'd1;
   localparam mode_type MODE_PEEK        = 3'd2;
   localparam mode_type MODE_SEARCH      = 3'd3;
   localparam mode_type MODE_PUSH_LESS   = 3'd4;
   localparam mode_type MODE_PUSH_UNIQUE = 3'd5;
   localparam mode_type MODE_CLEAR       = 3'd6;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_EMPTY = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;
   localparam status_type STAT_COND  = 2'd3;

endpackage

@@ rtl/core/lifo_stack_with_search_top.sv @@
// Search and push-unique scan the stored words and stop early at a match.
// One item at a time; the one-port word memory is read one word per cycle during a search.
// Reset: synchronous; the fill count clears at once, memory contents stay undefined
// and need no clearing pass since only written entries are ever read.
module lifo_stack_with_search_top
   import lifo_srch_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // [31:0] data_value
   input  logic [MODE_W-1:0] req_tuser,  // [2:0] mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [1:0] status, [33:2] read_value, [34] found,
                                         // [41:35] depth_used, [47:42] zero
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TOP,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   mode_type mode_ff, mode_in;
   logic signed [WORD_W-1:0] data_ff, data_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   status_type status_ff, status_in;
   logic signed [WORD_W-1:0] rd_ff, rd_in;
   logic found_ff, found_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [WORD_W-1:0] mem [STACK_DEPTH];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata;

   logic full, empty, hit, last;

   assign full  = (fill_ff == CNT_W'(STACK_DEPTH));
   assign empty = (fill_ff == '0);
   assign hit   = (mem_rdata_ff == data_ff);
   assign last  = (ptr_ff == fill_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      data_in       = data_ff;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      found_in      = found_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_we        = 1'b0;
      mem_addr      = '0;
      mem_wdata     = data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tuser;
               data_in   = req_tdata;
               status_in = STAT_OK;
               rd_in     = '0;
               found_in  = 1'b0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FIN;
            case (mode_ff)
               MODE_PUSH: begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     mem_addr = fill_ff[ADDR_W-1:0];
                     fill_in  = fill_ff + CNT_W'(1);
                  end
               end
               MODE_POP, MODE_PEEK, MODE_PUSH_LESS: begin
                  if (empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     mem_addr = ADDR_W'(fill_ff - CNT_W'(1));
                     state_in = ST_TOP;
                  end
               end
               MODE_SEARCH, MODE_PUSH_UNIQUE: begin
                  if (!empty) begin
                     mem_addr = '0;
                     ptr_in   = CNT_W'(1);
                     state_in = ST_SCAN;
                  end else if (mode_ff == MODE_PUSH_UNIQUE) begin
                     mem_we   = 1'b1;
                     mem_addr = '0;
                     fill_in  = CNT_W'(1);
                  end
               end
               MODE_CLEAR: begin
                  fill_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_TOP: begin
            state_in = ST_FIN;
            case (mode_ff)
               MODE_POP: begin
                  rd_in   = mem_rdata_ff;
                  fill_in = fill_ff - CNT_W'(1);
               end
               MODE_PEEK: begin
                  rd_in = mem_rdata_ff;
               end
               default: begin
                  if (!(data_ff < $signed(mem_rdata_ff))) begin
                     status_in = STAT_COND;
                  end else if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     mem_addr = fill_ff[ADDR_W-1:0];
                     fill_in  = fill_ff + CNT_W'(1);
                  end
               end
            endcase
         end
         ST_SCAN: begin
            if (hit) begin
               found_in = 1'b1;
               if (mode_ff == MODE_PUSH_UNIQUE) begin
                  status_in = STAT_COND;
               end
               state_in = ST_FIN;
            end else if (last) begin
               if (mode_ff == MODE_PUSH_UNIQUE) begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     mem_addr = fill_ff[ADDR_W-1:0];
                     fill_in  = fill_ff + CNT_W'(1);
                  end
               end
               state_in = ST_FIN;
            end else begin
               mem_addr = ptr_ff[ADDR_W-1:0];
               ptr_in   = ptr_ff + CNT_W'(1);
            end
         end
         ST_FIN: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {(RSP_W - DEPTH_W - 1 - WORD_W - STATUS_W)'(0),
                                DEPTH_W'(fill_ff), found_ff, rd_ff, status_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      mode_ff      <= mode_in;
      data_ff      <= data_in;
      ptr_ff       <= ptr_in;
      status_ff    <= status_in;
      rd_ff        <= rd_in;
      found_ff     <= found_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end else begin
         mem_rdata_ff <= mem[mem_addr];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(STACK_DEPTH))
      else $error("fill count beyond stack depth");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !full)
      else $error("write into full store");

   a_idle_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(fill_ff))
      else $error("fill count moved while idle");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finish state");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import lifo_srch_pkg::*;

   localparam int STACK_DEPTH = DEF_STACK_DEPTH;
   localparam int DIR_N       = 25;
   localparam int RAND_ITEMS  = 460;
   localparam mode_type MODE_NOP = 3'd7;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] rd;
      logic              found;
      logic [DEPTH_W-1:0] depth;
   } stack_rsp_type;

   typedef struct packed {
      mode_type          mode;
      logic [WORD_W-1:0] data;
      logic [6:0]        reps;
      logic              typed;
      status_type        st;
      logic [WORD_W-1:0] rd;
      logic              fnd;
      logic [DEPTH_W-1:0] dep;
   } dir_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // [31:0] data_value
   logic [MODE_W-1:0] req_tuser;  // [2:0] mode
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // [1:0] status, [33:2] read_value, [34] found,
                                  // [41:35] depth_used, [47:42] zero

   logic [WORD_W-1:0] model_words [STACK_DEPTH];
   int unsigned       model_fill;
   stack_rsp_type     pending_rsp_q [$];
   dir_row_type       dir_rows [DIR_N];

   int  items_sent;
   int  rsp_count;
   int  bad_count;
   int  full_refusals;
   int  peak_fill;
   int  mode_hits [8];
   bit  no_idle;

   lifo_stack_with_search_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_500_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic status_type model_push(input logic [WORD_W-1:0] w);
      if (model_fill >= STACK_DEPTH) return STAT_FULL;
      model_words[model_fill] = w;
      model_fill++;
      return STAT_OK;
   endfunction

   function automatic logic model_holds(input logic [WORD_W-1:0] w);
      for (int i = 0; i < model_fill; i++) begin
         if (model_words[i] == w) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic stack_rsp_type stack_predict(input mode_type m,
                                                   input logic [WORD_W-1:0] w);
      stack_rsp_type r;
      r = '0;
      case (m)
         MODE_PUSH: r.status = model_push(w);
         MODE_POP: begin
            if (model_fill == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.rd = model_words[model_fill-1];
               model_fill--;
            end
         end
         MODE_PEEK: begin
            if (model_fill == 0) r.status = STAT_EMPTY;
            else r.rd = model_words[model_fill-1];
         end
         MODE_SEARCH: r.found = model_holds(w);
         MODE_PUSH_LESS: begin
            if (model_fill == 0) r.status = STAT_EMPTY;
            else if (!($signed(w) < $signed(model_words[model_fill-1])))
               r.status = STAT_COND;
            else r.status = model_push(w);
         end
         MODE_PUSH_UNIQUE: begin
            if (model_holds(w)) begin
               r.found  = 1'b1;
               r.status = STAT_COND;
            end else begin
               r.status = model_push(w);
            end
         end
         MODE_CLEAR: model_fill = 0;
         default: ;
      endcase
      r.depth = 7'(model_fill);
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel >= 4 && sel <= 6 && model_fill > 0)
         return model_words[$urandom_range(0, model_fill-1)];
      if (sel == 7) begin
         case ($urandom_range(0, 3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            default: return '1;
         endcase
      end
      if (sel >= 8) return 32'($signed($urandom_range(0, 15)) - 8);
      return $urandom;
   endfunction

   task automatic send_item(input mode_type m, input logic [WORD_W-1:0] w,
                            input bit typed, input stack_rsp_type typed_rsp);
      int gap;
      stack_rsp_type pred;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = w;
      req_tuser  = m;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      pred = stack_predict(m, w);
      pending_rsp_q = {pending_rsp_q, (typed ? typed_rsp : pred)};
      items_sent++;
      mode_hits[m]++;
      if (pred.status == STAT_FULL) full_refusals++;
      if (model_fill > peak_fill) peak_fill = model_fill;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_rsp(input logic [RSP_W-1:0] d);
      stack_rsp_type e;
      if (pending_rsp_q.size() == 0) begin
         bad_count++;
         if (bad_count <= 10) $display("unexpected result item %h", d);
      end else begin
         e = pending_rsp_q.pop_front();
         rsp_count++;
         if (d[1:0] !== e.status || d[33:2] !== e.rd || d[34] !== e.found ||
             d[41:35] !== e.depth) begin
            bad_count++;
            if (bad_count <= 10)
               $display({"result %0d: expected st %0d rd %h fnd %0b dep %0d,",
                         " got st %0d rd %h fnd %0b dep %0d"},
                        rsp_count, e.status, e.rd, e.found, e.depth,
                        d[1:0], d[33:2], d[34], d[41:35]);
         end
      end
   endtask

   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         @(negedge clock);
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (reset || rsp_tvalid !== 1'b1) @(posedge clock);
         check_rsp(rsp_tdata);
      end
   end

   initial begin
      int rand_goal;
      int seg_kind;
      int seg_len;
      int pick;
      int dir_count;
      bit paused_once;
      mode_type m;
      logic [WORD_W-1:0] w;
      stack_rsp_type typed_rsp;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      no_idle    = 1'b0;
      model_fill = 0;
      items_sent = 0;
      rsp_count  = 0;
      bad_count  = 0;
      full_refusals = 0;
      peak_fill  = 0;
      paused_once = 1'b0;
      foreach (mode_hits[i]) mode_hits[i] = 0;

      dir_rows = '{
         '{MODE_POP,         32'd0,        7'd1,  1'b1, STAT_EMPTY, 32'd0,        1'b0, 7'd0},
         '{MODE_PEEK,        32'd0,        7'd1,  1'b1, STAT_EMPTY, 32'd0,        1'b0, 7'd0},
         '{MODE_SEARCH,      32'd0,        7'd1,  1'b1, STAT_OK,    32'd0,        1'b0, 7'd0},
         '{MODE_PUSH_LESS,   32'd5,        7'd1,  1'b1, STAT_EMPTY, 32'd0,        1'b0, 7'd0},
         '{MODE_PUSH_UNIQUE, 32'd5,        7'd1,  1'b1, STAT_OK,    32'd0,        1'b0, 7'd1},
         '{MODE_PUSH,        WORD_MAX,     7'd1,  1'b1, STAT_OK,    32'd0,        1'b0, 7'd2},
         '{MODE_PUSH,        WORD_MIN,     7'd1,  1'b1, STAT_OK,    32'd0,        1'b0, 7'd3},
         '{MODE_PEEK,        32'd0,        7'd1,  1'b1, STAT_OK,    WORD_MIN,     1'b0, 7'd3},
         '{MODE_PUSH_LESS,   WORD_MIN,     7'd1,  1'b1, STAT_COND,  32'd0,        1'b0, 7'd3},
         '{MODE_PUSH_UNIQUE, WORD_MAX,     7'd1,  1'b1, STAT_COND,  32'd0,        1'b1, 7'd3},
         '{MODE_SEARCH,      WORD_MAX,     7'd1,  1'b1, STAT_OK,    32'd0,        1'b1, 7'd3},
         '{MODE_SEARCH,      32'hffff_ffff, 7'd1, 1'b1, STAT_OK,    32'd0,        1'b0, 7'd3},
         '{MODE_POP,         32'd0,        7'd1,  1'b1, STAT_OK,    WORD_MIN,     1'b0, 7'd2},
         '{MODE_PUSH_LESS,   WORD_MIN,     7'd1,  1'b1, STAT_OK,    32'd0,        1'b0, 7'd3},
         '{MODE_NOP,         32'hffff_ffff, 7'd1, 1'b1, STAT_OK,    32'd0,        1'b0, 7'd3},
         '{MODE_CLEAR,       32'd0,        7'd1,  1'b1, STAT_OK,    32'd0,        1'b0, 7'd0},
         '{MODE_PUSH_UNIQUE, 32'h4000_0000, 7'd64, 1'b0, STAT_OK,   32'd0,        1'b0, 7'd0},
         '{MODE_PUSH,        32'd0,        7'd1,  1'b1, STAT_FULL,  32'd0,        1'b0, 7'd64},
         '{MODE_PUSH_LESS,   WORD_MIN,     7'd1,  1'b1, STAT_FULL,  32'd0,        1'b0, 7'd64},
         '{MODE_PUSH_UNIQUE, 32'h1234_5678, 7'd1, 1'b1, STAT_FULL,  32'd0,        1'b0, 7'd64},
         '{MODE_PUSH_UNIQUE, 32'h4000_0000, 7'd1, 1'b1, STAT_COND,  32'd0,        1'b1, 7'd64},
         '{MODE_SEARCH,      32'h4000_003f, 7'd1, 1'b1, STAT_OK,    32'd0,        1'b1, 7'd64},
         '{MODE_POP,         32'd0,        7'd1,  1'b1, STAT_OK,    32'h4000_003f, 1'b0, 7'd63},
         '{MODE_PUSH_LESS,   32'h4000_003e, 7'd1, 1'b1, STAT_COND,  32'd0,        1'b0, 7'd63},
         '{MODE_CLEAR,       32'd0,        7'd1,  1'b1, STAT_OK,    32'd0,        1'b0, 7'd0}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         typed_rsp = '{dir_rows[i].st, dir_rows[i].rd, dir_rows[i].fnd, dir_rows[i].dep};
         for (int r = 0; r < dir_rows[i].reps; r++)
            send_item(dir_rows[i].mode, dir_rows[i].data + r, dir_rows[i].typed, typed_rsp);
      end
      dir_count = items_sent;
      hold_until_drained();

      rand_goal = items_sent + RAND_ITEMS;
      while (items_sent < rand_goal) begin
         seg_kind = $urandom_range(0, 3);
         seg_len  = $urandom_range(10, 70);
         no_idle  = ($urandom_range(0, 4) == 0);
         if (!paused_once && items_sent > dir_count + RAND_ITEMS / 2) begin
            hold_until_drained();
            paused_once = 1'b1;
         end
         for (int k = 0; k < seg_len && items_sent < rand_goal; k++) begin
            pick = $urandom_range(0, 19);
            case (seg_kind)
               0: m = pick < 12 ? MODE_PUSH : pick < 16 ? MODE_PUSH_UNIQUE :
                      pick < 19 ? MODE_PUSH_LESS : MODE_PEEK;
               1: m = pick < 13 ? MODE_POP : pick < 16 ? MODE_PEEK :
                      pick < 19 ? MODE_SEARCH : MODE_PUSH;
               2: m = pick < 8 ? MODE_SEARCH : pick < 14 ? MODE_PUSH_UNIQUE :
                      pick < 17 ? MODE_PUSH : MODE_POP;
               default: m = mode_type'($urandom_range(0, 7));
            endcase
            if (m == MODE_PUSH_LESS && model_fill > 0 && $urandom_range(0, 1) == 1)
               w = model_words[model_fill-1] - 32'($urandom_range(1, 50));
            else
               w = pick_word();
            send_item(m, w, 1'b0, '0);
         end
      end

      no_idle = 1'b0;
      hold_until_drained();
      repeat (100) @(posedge clock);

      $display("Covered %0d items (%0d directed) and %0d results",
               items_sent, dir_count, rsp_count);
      $display("Per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
               mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
      $display("Pushes refused at full depth: %0d; deepest fill %0d of %0d",
               full_refusals, peak_fill, STACK_DEPTH);
      if (bad_count == 0 && pending_rsp_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
